// File: rtl/orl_pkg.sv
// Shared widths, operation and status codes, and the record type of the ring list.
package orl_pkg;

   localparam int FUNC_W   = 3;
   localparam int ID_W     = 32;
   localparam int REF_W    = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PREPEND = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP     = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_NEXT    = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_LIST    = 3'd6;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]  ticket_id;
      logic [REF_W-1:0] customer_ref;
      logic [REF_W-1:0] ride_ref;
   } orl_rec_type;

endpackage

// File: rtl/orl_if.sv
// Request and response channel interfaces with valid/ready handshake.
interface orl_req_if;
   logic                        valid;
   logic                        ready;
   logic [orl_pkg::FUNC_W-1:0]  func;
   logic [orl_pkg::ID_W-1:0]    ticket_id;
   logic [orl_pkg::REF_W-1:0]   customer_ref;
   logic [orl_pkg::REF_W-1:0]   ride_ref;

   modport source (output valid, func, ticket_id, customer_ref, ride_ref, input ready);
   modport sink   (input valid, func, ticket_id, customer_ref, ride_ref, output ready);
endinterface

interface orl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [orl_pkg::STATUS_W-1:0]  status;
   logic [orl_pkg::ID_W-1:0]      found_id;
   logic [orl_pkg::REF_W-1:0]     found_customer;
   logic [orl_pkg::REF_W-1:0]     found_ride;
   logic [orl_pkg::COUNT_W-1:0]   entry_count;
   logic                          last_of_run;

   modport source (output valid, status, found_id, found_customer, found_ride, entry_count,
                   last_of_run, input ready);
   modport sink   (input valid, status, found_id, found_customer, found_ride, entry_count,
                   last_of_run, output ready);
endinterface

// File: rtl/orl_store.sv
// Record memory addressed by list position, mapped onto ring slots from the head.
module orl_store #(
   parameter int CAPACITY = 16
) (
   input  logic                              clock,
   input  logic [$clog2(CAPACITY)-1:0]       head,
   input  logic [$clog2(CAPACITY)-1:0]       rd_pos,
   input  logic                              wr_en,
   input  logic [$clog2(CAPACITY)-1:0]       wr_pos,
   input  orl_pkg::orl_rec_type              wr_rec,
   output orl_pkg::orl_rec_type              rd_rec
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam logic [SLOT_W:0] CAP_EXT = (SLOT_W+1)'(CAPACITY);

   orl_pkg::orl_rec_type mem [CAPACITY];
   orl_pkg::orl_rec_type rd_rec_ff;

   logic [SLOT_W:0]   rd_sum;
   logic [SLOT_W:0]   wr_sum;
   logic [SLOT_W-1:0] rd_slot;
   logic [SLOT_W-1:0] wr_slot;

   // slot = (head + pos) mod CAPACITY; the sum stays below twice the capacity
   always_comb begin
      rd_sum = {1'b0, head} + {1'b0, rd_pos};
      wr_sum = {1'b0, head} + {1'b0, wr_pos};
      if (rd_sum >= CAP_EXT) begin
         rd_slot = SLOT_W'(rd_sum - CAP_EXT);
      end else begin
         rd_slot = rd_sum[SLOT_W-1:0];
      end
      if (wr_sum >= CAP_EXT) begin
         wr_slot = SLOT_W'(wr_sum - CAP_EXT);
      end else begin
         wr_slot = wr_sum[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= wr_rec;
      end
      rd_rec_ff <= mem[rd_slot];
   end

   assign rd_rec = rd_rec_ff;

endmodule

// File: rtl/orl_ctrl.sv
// Operation sequencer: scans, shifts and fetches records and drives the response register.
module orl_ctrl #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   orl_req_if.sink                       req,
   orl_rsp_if.source                     rsp,
   output logic [$clog2(CAPACITY)-1:0]   head,
   output logic [$clog2(CAPACITY)-1:0]   rd_pos,
   output logic                          wr_en,
   output logic [$clog2(CAPACITY)-1:0]   wr_pos,
   output orl_pkg::orl_rec_type          wr_rec,
   input  orl_pkg::orl_rec_type          rd_rec
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(CAPACITY - 1);
   localparam logic [SLOT_W-1:0] SLOT_ONE = SLOT_W'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE,
      S_FETCH,
      S_CAPTURE,
      S_EMIT
   } state_type;

   state_type                       state_ff, state_in;
   logic [SLOT_W-1:0]               head_ff, head_in;
   logic [CNT_W-1:0]                occ_ff, occ_in;
   logic [CNT_W-1:0]                ptr_ff, ptr_in;
   logic                            chk_valid_ff, chk_valid_in;
   logic [CNT_W-1:0]                chk_pos_ff, chk_pos_in;
   logic [orl_pkg::FUNC_W-1:0]      func_ff, func_in;
   logic [orl_pkg::ID_W-1:0]        key_ff, key_in;
   orl_pkg::orl_rec_type            res_rec_ff, res_rec_in;
   logic [orl_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                            res_last_ff, res_last_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [orl_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   orl_pkg::orl_rec_type            rsp_rec_ff, rsp_rec_in;
   logic [orl_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            mv_wr_en;
   logic                            emit_wr_en;
   logic [CNT_W-1:0]                occ_new;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      occ_in        = occ_ff;
      ptr_in        = ptr_ff;
      chk_valid_in  = chk_valid_ff;
      chk_pos_in    = chk_pos_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      res_rec_in    = res_rec_ff;
      res_status_in = res_status_ff;
      res_last_in   = res_last_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      mv_wr_en      = 1'b0;
      emit_wr_en    = 1'b0;
      occ_new       = occ_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               func_in       = req.func;
               key_in        = req.ticket_id;
               res_rec_in    = '{ticket_id: req.ticket_id, customer_ref: req.customer_ref,
                                 ride_ref: req.ride_ref};
               res_status_in = orl_pkg::STATUS_OK;
               res_last_in   = 1'b1;
               ptr_in        = '0;
               chk_valid_in  = 1'b0;
               state_in      = S_EMIT;
               unique case (req.func)
                  orl_pkg::FUNC_APPEND, orl_pkg::FUNC_PREPEND: begin
                     if (occ_ff >= CAP_CNT) begin
                        res_status_in = orl_pkg::STATUS_FULL;
                        res_rec_in    = '0;
                     end
                  end
                  orl_pkg::FUNC_REMOVE, orl_pkg::FUNC_SEARCH, orl_pkg::FUNC_NEXT: begin
                     if (occ_ff == '0) begin
                        res_status_in = orl_pkg::STATUS_EMPTY;
                        res_rec_in    = '0;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  orl_pkg::FUNC_POP, orl_pkg::FUNC_LIST: begin
                     if (occ_ff == '0) begin
                        res_status_in = orl_pkg::STATUS_EMPTY;
                        res_rec_in    = '0;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                     res_rec_in = '0;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // issue one read per cycle, compare the record read the cycle before
            chk_pos_in = ptr_ff;
            if (ptr_ff < occ_ff) begin
               ptr_in       = ptr_ff + CNT_ONE;
               chk_valid_in = 1'b1;
            end else begin
               chk_valid_in = 1'b0;
            end
            if (chk_valid_ff && (rd_rec.ticket_id == key_ff)) begin
               chk_valid_in  = 1'b0;
               res_status_in = orl_pkg::STATUS_OK;
               res_rec_in    = rd_rec;
               if (func_ff == orl_pkg::FUNC_SEARCH) begin
                  state_in = S_EMIT;
               end else if (func_ff == orl_pkg::FUNC_NEXT) begin
                  // wrap from the tail back to the head
                  if (chk_pos_ff + CNT_ONE == occ_ff) begin
                     ptr_in = '0;
                  end else begin
                     ptr_in = chk_pos_ff + CNT_ONE;
                  end
                  state_in = S_FETCH;
               end else begin
                  ptr_in   = chk_pos_ff + CNT_ONE;
                  state_in = S_MOVE;
               end
            end else if (chk_valid_ff && (chk_pos_ff == occ_ff - CNT_ONE)) begin
               res_status_in = orl_pkg::STATUS_NOTFOUND;
               res_rec_in    = '0;
               state_in      = S_EMIT;
            end
         end

         S_MOVE: begin
            // close the gap: read position k, write it to k-1 in the following cycle
            chk_pos_in = ptr_ff - CNT_ONE;
            if (ptr_ff < occ_ff) begin
               ptr_in       = ptr_ff + CNT_ONE;
               chk_valid_in = 1'b1;
            end else begin
               chk_valid_in = 1'b0;
            end
            mv_wr_en = chk_valid_ff;
            if (!chk_valid_ff && (ptr_ff >= occ_ff)) begin
               state_in = S_EMIT;
            end
         end

         S_FETCH: begin
            state_in = S_CAPTURE;
         end

         S_CAPTURE: begin
            res_rec_in    = rd_rec;
            res_status_in = orl_pkg::STATUS_OK;
            res_last_in   = (func_ff != orl_pkg::FUNC_LIST) || (ptr_ff == occ_ff - CNT_ONE);
            state_in      = S_EMIT;
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               if (res_status_ff == orl_pkg::STATUS_OK) begin
                  unique case (func_ff)
                     orl_pkg::FUNC_APPEND: begin
                        emit_wr_en = 1'b1;
                        occ_new    = occ_ff + CNT_ONE;
                     end
                     orl_pkg::FUNC_PREPEND: begin
                        emit_wr_en = 1'b1;
                        occ_new    = occ_ff + CNT_ONE;
                        head_in    = (head_ff == '0) ? SLOT_TOP : head_ff - SLOT_ONE;
                     end
                     orl_pkg::FUNC_REMOVE: begin
                        occ_new = occ_ff - CNT_ONE;
                     end
                     orl_pkg::FUNC_POP: begin
                        occ_new = occ_ff - CNT_ONE;
                        head_in = (head_ff == SLOT_TOP) ? '0 : head_ff + SLOT_ONE;
                     end
                     default: begin
                        occ_new = occ_ff;
                     end
                  endcase
               end
               occ_in        = occ_new;
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_rec_in    = res_rec_ff;
               rsp_count_in  = orl_pkg::COUNT_W'(occ_new);
               rsp_last_in   = res_last_ff;
               if ((func_ff == orl_pkg::FUNC_LIST) && !res_last_ff) begin
                  ptr_in   = ptr_ff + CNT_ONE;
                  state_in = S_FETCH;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         ptr_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         occ_ff        <= occ_in;
         ptr_ff        <= ptr_in;
         chk_valid_ff  <= chk_valid_in;
         chk_pos_ff    <= chk_pos_in;
         func_ff       <= func_in;
         key_ff        <= key_in;
         res_rec_ff    <= res_rec_in;
         res_status_ff <= res_status_in;
         res_last_ff   <= res_last_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_rec_ff    <= rsp_rec_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // memory port: shift writes and insert writes never fall in the same cycle
   assign head   = head_ff;
   assign rd_pos = ptr_ff[SLOT_W-1:0];
   assign wr_en  = mv_wr_en | emit_wr_en;
   assign wr_pos = mv_wr_en ? chk_pos_ff[SLOT_W-1:0] :
                   (func_ff == orl_pkg::FUNC_PREPEND) ? SLOT_TOP : occ_ff[SLOT_W-1:0];
   assign wr_rec = mv_wr_en ? rd_rec : res_rec_ff;

   assign req.ready          = (state_ff == S_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.found_id       = rsp_rec_ff.ticket_id;
   assign rsp.found_customer = rsp_rec_ff.customer_ref;
   assign rsp.found_ride     = rsp_rec_ff.ride_ref;
   assign rsp.entry_count    = rsp_count_ff;
   assign rsp.last_of_run    = rsp_last_ff;

endmodule

// File: rtl/ordered_ring_list_with_key_ops.sv
// Ordered ring list, one request at a time. Insert, full, empty and unused-code requests go
// straight to the emit step; pop fetches the head record, captures it and emits it. Search
// reads one record a cycle until a match or the tail; next-after then fetches the record after
// the match (the head after the tail); remove shifts each later record down one position.
// List all fetches, captures and emits each record in turn; a held response stalls the emit step.
// Reset (synchronous, active high) empties the list and zeroes the head slot; memory is not cleared.
module ordered_ring_list_with_key_ops #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   orl_req_if.sink     req_ch,
   orl_rsp_if.source   rsp_ch
);

   localparam int SLOT_W = $clog2(CAPACITY);

   logic [SLOT_W-1:0]     head;
   logic [SLOT_W-1:0]     rd_pos;
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_pos;
   orl_pkg::orl_rec_type  wr_rec;
   orl_pkg::orl_rec_type  rd_rec;

   orl_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .rsp    (rsp_ch),
      .head   (head),
      .rd_pos (rd_pos),
      .wr_en  (wr_en),
      .wr_pos (wr_pos),
      .wr_rec (wr_rec),
      .rd_rec (rd_rec)
   );

   orl_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock  (clock),
      .head   (head),
      .rd_pos (rd_pos),
      .wr_en  (wr_en),
      .wr_pos (wr_pos),
      .wr_rec (wr_rec),
      .rd_rec (rd_rec)
   );

endmodule

// File: sim/tb_ordered_ring_list_with_key_ops.sv
// Self-checking testbench for the ordered ring list with key operations.
`timescale 1ns / 1ps

module tb_ordered_ring_list_with_key_ops;

   localparam int CAPACITY      = 16;
   localparam int IDLE_LIMIT    = 3000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 60;
   localparam logic [orl_pkg::FUNC_W-1:0] FUNC_UNUSED = 3'd7;

   typedef struct packed {
      logic [orl_pkg::STATUS_W-1:0] status;
      logic [orl_pkg::ID_W-1:0]     found_id;
      logic [orl_pkg::REF_W-1:0]    found_customer;
      logic [orl_pkg::REF_W-1:0]    found_ride;
      logic [orl_pkg::COUNT_W-1:0]  entry_count;
      logic                         last_of_run;
   } reply_type;

   logic clock;
   logic reset;

   orl_req_if req_bus ();
   orl_rsp_if rsp_bus ();

   ordered_ring_list_with_key_ops #(.CAPACITY(CAPACITY)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Shadow of the list, head first, and the replies it predicts.
   orl_pkg::orl_rec_type ring_q[$];
   reply_type            pending_replies[$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_req_cnt;
   int mismatch_cnt;
   int request_cnt;
   int reply_cnt;
   int list_run_cnt;
   int refused_cnt;
   int wrap_cnt;
   int full_seen_cnt;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_reply(input logic [orl_pkg::STATUS_W-1:0] status,
                                      input bit has_rec, input orl_pkg::orl_rec_type rec,
                                      input bit last);
      reply_type r;
      r.status         = status;
      r.found_id       = has_rec ? rec.ticket_id : '0;
      r.found_customer = has_rec ? rec.customer_ref : '0;
      r.found_ride     = has_rec ? rec.ride_ref : '0;
      r.entry_count    = 5'(ring_q.size());
      r.last_of_run    = last;
      pending_replies.push_back(r);
   endfunction

   // Apply one request to the shadow list and queue the replies it causes.
   function automatic void apply_ticket_op(input logic [orl_pkg::FUNC_W-1:0] func,
                                           input orl_pkg::orl_rec_type rec);
      int pos;
      int n;
      orl_pkg::orl_rec_type got;
      pos = -1;
      n   = ring_q.size();
      case (func)
         orl_pkg::FUNC_APPEND, orl_pkg::FUNC_PREPEND: begin
            if (n >= CAPACITY) begin
               refused_cnt++;
               push_reply(orl_pkg::STATUS_FULL, 1'b0, rec, 1'b1);
            end else begin
               if (func == orl_pkg::FUNC_APPEND) ring_q.push_back(rec);
               else ring_q.push_front(rec);
               if (ring_q.size() == CAPACITY) full_seen_cnt++;
               push_reply(orl_pkg::STATUS_OK, 1'b1, rec, 1'b1);
            end
         end
         orl_pkg::FUNC_REMOVE, orl_pkg::FUNC_SEARCH, orl_pkg::FUNC_NEXT: begin
            if (n == 0) begin
               push_reply(orl_pkg::STATUS_EMPTY, 1'b0, rec, 1'b1);
            end else begin
               foreach (ring_q[i]) begin
                  if (pos < 0 && ring_q[i].ticket_id == rec.ticket_id) pos = i;
               end
               if (pos < 0) begin
                  push_reply(orl_pkg::STATUS_NOTFOUND, 1'b0, rec, 1'b1);
               end else if (func == orl_pkg::FUNC_REMOVE) begin
                  got = ring_q[pos];
                  ring_q.delete(pos);
                  push_reply(orl_pkg::STATUS_OK, 1'b1, got, 1'b1);
               end else if (func == orl_pkg::FUNC_SEARCH) begin
                  push_reply(orl_pkg::STATUS_OK, 1'b1, ring_q[pos], 1'b1);
               end else begin
                  if (pos == n - 1) wrap_cnt++;
                  push_reply(orl_pkg::STATUS_OK, 1'b1, ring_q[(pos + 1) % n], 1'b1);
               end
            end
         end
         orl_pkg::FUNC_POP: begin
            if (n == 0) begin
               push_reply(orl_pkg::STATUS_EMPTY, 1'b0, rec, 1'b1);
            end else begin
               got = ring_q.pop_front();
               push_reply(orl_pkg::STATUS_OK, 1'b1, got, 1'b1);
            end
         end
         orl_pkg::FUNC_LIST: begin
            if (n == 0) begin
               push_reply(orl_pkg::STATUS_EMPTY, 1'b0, rec, 1'b1);
            end else begin
               list_run_cnt++;
               foreach (ring_q[i]) push_reply(orl_pkg::STATUS_OK, 1'b1, ring_q[i], i == n - 1);
            end
         end
         default: push_reply(orl_pkg::STATUS_OK, 1'b0, rec, 1'b1);
      endcase
   endfunction

   // Offer one request from a falling edge; return at the falling edge after acceptance.
   task automatic send_ticket_op(input logic [orl_pkg::FUNC_W-1:0] func,
                                 input logic [orl_pkg::ID_W-1:0] id,
                                 input logic [orl_pkg::REF_W-1:0] cust,
                                 input logic [orl_pkg::REF_W-1:0] ride);
      orl_pkg::orl_rec_type rec;
      rec.ticket_id    = id;
      rec.customer_ref = cust;
      rec.ride_ref     = ride;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.func         = func;
      req_bus.ticket_id    = id;
      req_bus.customer_ref = cust;
      req_bus.ride_ref     = ride;
      req_bus.valid        = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      request_cnt++;
      apply_ticket_op(func, rec);
      @(negedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin : receiver
      int hold_done_cnt;
      hold_done_cnt = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req_cnt != hold_done_cnt) begin
            hold_done_cnt = hold_req_cnt;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void check_field(input string name,
                                       input logic [orl_pkg::ID_W-1:0] exp_val,
                                       input logic [orl_pkg::ID_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         mismatch_cnt++;
      end
   endfunction

   always @(posedge clock) begin
      reply_type exp_r;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         reply_cnt++;
         if (pending_replies.size() == 0) begin
            $error("response with no request outstanding: status %0h id %0h",
                   rsp_bus.status, rsp_bus.found_id);
            mismatch_cnt++;
         end else begin
            exp_r = pending_replies.pop_front();
            check_field("status", 32'(exp_r.status), 32'(rsp_bus.status));
            check_field("found_id", exp_r.found_id, rsp_bus.found_id);
            check_field("found_customer", 32'(exp_r.found_customer),
                        32'(rsp_bus.found_customer));
            check_field("found_ride", 32'(exp_r.found_ride), 32'(rsp_bus.found_ride));
            check_field("entry_count", 32'(exp_r.entry_count), 32'(rsp_bus.entry_count));
            check_field("last_of_run", 32'(exp_r.last_of_run), 32'(rsp_bus.last_of_run));
         end
      end
   end

   // End the run if nothing moves on either channel for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no handshake for %0d cycles, %0d replies outstanding",
               IDLE_LIMIT, pending_replies.size());
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [orl_pkg::ID_W-1:0] pick_ticket_id();
      int sel;
      sel = $urandom_range(99);
      if (ring_q.size() != 0 && sel < 60)
         return ring_q[$urandom_range(ring_q.size() - 1)].ticket_id;
      if (sel < 85) return 32'($urandom_range(3));
      return $urandom;
   endfunction

   task automatic test_empty_list();
      send_ticket_op(orl_pkg::FUNC_REMOVE, 32'h0, 16'h0, 16'h0);
      send_ticket_op(orl_pkg::FUNC_POP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_ticket_op(orl_pkg::FUNC_SEARCH, 32'h1, 16'h0, 16'h0);
      send_ticket_op(orl_pkg::FUNC_NEXT, 32'h1, 16'h0, 16'h0);
      send_ticket_op(orl_pkg::FUNC_LIST, 32'h0, 16'h0, 16'h0);
      send_ticket_op(FUNC_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_basic_ops();
      send_ticket_op(orl_pkg::FUNC_APPEND, 32'h0, 16'hFFFF, 16'h0);
      send_ticket_op(orl_pkg::FUNC_NEXT, 32'h0, 16'h0, 16'h0);  // single record: match itself
      send_ticket_op(orl_pkg::FUNC_SEARCH, 32'h0, 16'h0, 16'h0);
      send_ticket_op(orl_pkg::FUNC_PREPEND, 32'hFFFF_FFFF, 16'h0, 16'hFFFF);
      send_ticket_op(orl_pkg::FUNC_APPEND, 32'h0, 16'h1234, 16'h5678); // repeated ID at the tail
      send_ticket_op(orl_pkg::FUNC_APPEND, 32'h8000_0001, 16'hA5A5, 16'h5A5A);
      send_ticket_op(orl_pkg::FUNC_LIST, 32'h0, 16'h0, 16'h0);
      send_ticket_op(orl_pkg::FUNC_NEXT, 32'h8000_0001, 16'h0, 16'h0); // tail wraps to head
      send_ticket_op(orl_pkg::FUNC_SEARCH, 32'h0, 16'h0, 16'h0);  // earliest of the repeats
      send_ticket_op(orl_pkg::FUNC_SEARCH, 32'h7777_7777, 16'h0, 16'h0);
      send_ticket_op(orl_pkg::FUNC_NEXT, 32'h7777_7777, 16'h0, 16'h0);
      send_ticket_op(orl_pkg::FUNC_REMOVE, 32'h7777_7777, 16'h0, 16'h0);
      send_ticket_op(orl_pkg::FUNC_REMOVE, 32'h0, 16'h0, 16'h0);
      send_ticket_op(orl_pkg::FUNC_LIST, 32'h0, 16'h0, 16'h0);
      send_ticket_op(orl_pkg::FUNC_POP, 32'h0, 16'h0, 16'h0);
      send_ticket_op(FUNC_UNUSED, 32'h0, 16'h0, 16'h0);
   endtask

   task automatic test_full_list();
      int k;
      for (k = 0; ring_q.size() < CAPACITY; k++)
         send_ticket_op((k % 2) ? orl_pkg::FUNC_PREPEND : orl_pkg::FUNC_APPEND, 32'(k % 5),
                        16'($urandom), 16'($urandom));
      send_ticket_op(orl_pkg::FUNC_APPEND, 32'h5555_AAAA, 16'h1, 16'h1);
      send_ticket_op(orl_pkg::FUNC_PREPEND, 32'hAAAA_5555, 16'h2, 16'h2);
      send_ticket_op(orl_pkg::FUNC_LIST, 32'h0, 16'h0, 16'h0);
      send_ticket_op(orl_pkg::FUNC_NEXT, ring_q[CAPACITY - 1].ticket_id, 16'h0, 16'h0);
      send_ticket_op(orl_pkg::FUNC_REMOVE, ring_q[CAPACITY / 2].ticket_id, 16'h0, 16'h0);
      while (ring_q.size() != 0) send_ticket_op(orl_pkg::FUNC_POP, 32'h0, 16'h0, 16'h0);
      send_ticket_op(orl_pkg::FUNC_POP, 32'h0, 16'h0, 16'h0);
   endtask

   // Random mix: inserts dominate when the list is short, removals when it is long.
   task automatic test_random(input int n_items);
      int k;
      int ins_pct;
      int sel;
      logic [orl_pkg::FUNC_W-1:0] func;
      for (k = 0; k < n_items; k++) begin
         if (ring_q.size() <= 3) ins_pct = 60;
         else if (ring_q.size() >= 14) ins_pct = 25;
         else ins_pct = 40;
         if ($urandom_range(99) < ins_pct) begin
            func = $urandom_range(1) ? orl_pkg::FUNC_PREPEND : orl_pkg::FUNC_APPEND;
         end else begin
            sel = $urandom_range(99);
            if (sel < 22) func = orl_pkg::FUNC_REMOVE;
            else if (sel < 40) func = orl_pkg::FUNC_POP;
            else if (sel < 60) func = orl_pkg::FUNC_SEARCH;
            else if (sel < 82) func = orl_pkg::FUNC_NEXT;
            else if (sel < 96) func = orl_pkg::FUNC_LIST;
            else func = FUNC_UNUSED;
         end
         send_ticket_op(func, pick_ticket_id(), 16'($urandom), 16'($urandom));
      end
   endtask

   // Hold the receiver off while requests keep coming so the input stalls.
   task automatic test_backpressure();
      int k;
      hold_req_cnt++;
      for (k = 0; k < 8; k++)
         send_ticket_op(k < 6 ? orl_pkg::FUNC_APPEND : orl_pkg::FUNC_LIST, pick_ticket_id(),
                        16'($urandom), 16'($urandom));
   endtask

   initial begin : main_seq
      req_bus.valid        = 1'b0;
      req_bus.func         = orl_pkg::FUNC_APPEND;
      req_bus.ticket_id    = '0;
      req_bus.customer_ref = '0;
      req_bus.ride_ref     = '0;
      hold_req_cnt  = 0;
      send_idle_pct = 11;
      recv_idle_pct = 64;
      reset         = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_list();
      test_basic_ops();
      test_full_list();
      test_random(115);

      send_idle_pct = 64;
      recv_idle_pct = 11;
      test_random(115);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(115);

      req_bus.valid = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses, %0d mismatches.",
               request_cnt, reply_cnt, mismatch_cnt);
      $display("List walks %0d, full list reached %0d times, inserts refused %0d, wraps %0d.",
               list_run_cnt, full_seen_cnt, refused_cnt, wrap_cnt);
      if (mismatch_cnt == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
